// ===== hw/rtl/base64_stream_decoder_assert.svh =====
// assertion macros for the base64 stream decoder
// no dependencies; taken in by the top level
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define B64D_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// shared types, codes and the character lookup of the base64 stream decoder
// no dependencies
package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [23:0] MAX_BYTES_RESET = 24'h100000;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_CHAR       = 3'd1,
    ST_DATA_AFTER_PAD = 3'd2,
    ST_BAD_PAD_POS    = 3'd3,
    ST_BAD_LENGTH     = 3'd4,
    ST_EMPTY_OR_LONG  = 3'd5
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [2:0] status_code;
    logic [23:0] byte_count;
    logic       run_last;
  } out_word_t;

  // one record per input character that yields results
  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [1:0]  nbytes;
    logic        has_status;
    status_e     status;
    logic [23:0] count;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // bit 6 set when the character is outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) r = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) r = 7'(c - 8'h47);
    else if (c >= 8'h30 && c <= 8'h39) r = 7'(c + 8'd4);
    else if (c == 8'h2B) r = 7'd62;
    else if (c == 8'h2F) r = 7'd63;
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// front end: classifies each character, assembles groups, tracks errors
// depends on b64d_pkg
module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  b64d_pkg::in_word_t in_word_i,
  input  logic [23:0]        max_bytes_i,
  output b64d_pkg::q_wr_t    q_wr_o
);
  import b64d_pkg::*;

  logic [17:0] hold_q, hold_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  mask_q, mask_d;
  logic        pad_seen_q, pad_seen_d;
  logic [2:0]  pad_total_q, pad_total_d;
  status_e     err_q, err_d;
  logic [23:0] bytes_q, bytes_d;

  logic        blank, pad, go;
  logic [6:0]  sx;
  logic [5:0]  v;
  logic [1:0]  n;
  logic [24:0] sum;
  status_e     fin_err;
  logic [23:0] count;

  always_comb begin
    blank = in_word_i.char_in inside {8'h20, [8'h09:8'h0D]};
    pad   = (in_word_i.char_in == CHAR_PAD);
    sx    = sextet_of(in_word_i.char_in);
    v     = pad ? 6'd0 : sx[5:0];

    hold_d      = hold_q;
    pos_d       = pos_q;
    mask_d      = mask_q;
    pad_seen_d  = pad_seen_q;
    pad_total_d = pad_total_q;
    err_d       = err_q;
    bytes_d     = bytes_q;
    n           = 2'd0;
    go          = 1'b0;
    sum         = '0;
    fin_err     = ST_OK;
    count       = '0;

    if (accept_i && !blank && err_q == ST_OK) begin
      go = 1'b1;
      if (pad) begin
        pad_total_d = (pad_total_q == 3'd7) ? 3'd7 : pad_total_q + 3'd1;
        pad_seen_d  = 1'b1;
        if (pad_total_d > 3'd2) begin
          err_d = ST_BAD_LENGTH;
          go    = 1'b0;
        end
      end else if (pad_seen_q) begin
        err_d = ST_DATA_AFTER_PAD;
        go    = 1'b0;
      end else if (sx[6]) begin
        err_d = ST_BAD_CHAR;
        go    = 1'b0;
      end

      if (go) begin
        case (pos_q)
          2'd0: begin
            hold_d = {v, 12'd0};
            if (pad) mask_d = mask_q | 2'b01;
            pos_d = 2'd1;
          end
          2'd1: begin
            hold_d = {hold_q[17:12], v, 6'd0};
            if (pad) mask_d = mask_q | 2'b01;
            pos_d = 2'd2;
          end
          2'd2: begin
            hold_d = {hold_q[17:6], v};
            if (pad) mask_d = mask_q | 2'b10;
            pos_d = 2'd3;
          end
          default: begin
            // group complete
            pos_d  = 2'd0;
            mask_d = 2'b00;
            if (mask_q[0]) begin
              err_d = ST_BAD_PAD_POS;
            end else if (mask_q[1] && !pad) begin
              err_d = ST_BAD_LENGTH;
            end else begin
              n   = mask_q[1] ? 2'd1 : (pad ? 2'd2 : 2'd3);
              sum = {1'b0, bytes_q} + 25'(n);
              if (sum > {1'b0, max_bytes_i}) begin
                err_d = ST_EMPTY_OR_LONG;
                n     = 2'd0;
              end else begin
                bytes_d = sum[23:0];
              end
            end
          end
        endcase
      end
    end

    if (accept_i && in_word_i.is_final) begin
      fin_err = err_d;
      if (err_d == ST_OK) begin
        if (pos_d != 2'd0) fin_err = ST_BAD_LENGTH;
        else if (bytes_d == 24'd0) fin_err = ST_EMPTY_OR_LONG;
      end
      count       = bytes_d;
      hold_d      = '0;
      pos_d       = '0;
      mask_d      = '0;
      pad_seen_d  = 1'b0;
      pad_total_d = '0;
      err_d       = ST_OK;
      bytes_d     = '0;
    end

    q_wr_o.push           = accept_i && (n != 2'd0 || in_word_i.is_final);
    q_wr_o.rec.b0         = {hold_q[17:12], hold_q[11:10]};
    q_wr_o.rec.b1         = {hold_q[9:6], hold_q[5:2]};
    q_wr_o.rec.b2         = {hold_q[1:0], v};
    q_wr_o.rec.nbytes     = n;
    q_wr_o.rec.has_status = in_word_i.is_final;
    q_wr_o.rec.status     = fin_err;
    q_wr_o.rec.count      = count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      pos_q       <= '0;
      mask_q      <= '0;
      pad_seen_q  <= 1'b0;
      pad_total_q <= '0;
      err_q       <= ST_OK;
      bytes_q     <= '0;
    end else begin
      hold_q      <= hold_d;
      pos_q       <= pos_d;
      mask_q      <= mask_d;
      pad_seen_q  <= pad_seen_d;
      pad_total_q <= pad_total_d;
      err_q       <= err_d;
      bytes_q     <= bytes_d;
    end
  end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// record queue between front and back end
// depends on b64d_pkg
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64d_pkg::q_wr_t  q_wr_i,
  input  logic             pop_i,
  output b64d_pkg::rec_t   head_o,
  output b64d_pkg::q_stat_t stat_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    do_push  = q_wr_i.push && (cnt_q != CntW'(Depth));
    do_pop   = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= q_wr_i.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== hw/rtl/b64d_back.sv =====
// back end: unpacks one record into data and status words
// depends on b64d_pkg
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::rec_t      head_i,
  input  b64d_pkg::q_stat_t   q_stat_i,
  output logic                q_pop_o,
  input  logic                pop,
  output logic                empty,
  output b64d_pkg::out_word_t out_word_o
);
  import b64d_pkg::*;

  rec_t       rec_q, rec_d;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       is_data, last, taken, load;

  always_comb begin
    is_data = (idx_q < rec_q.nbytes);
    last    = is_data ? (idx_q == rec_q.nbytes - 2'd1) && !rec_q.has_status : 1'b1;
    taken   = pop && valid_q;
    load    = !valid_q || (taken && last);
    q_pop_o = load && !q_stat_i.empty;

    rec_d   = rec_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !q_stat_i.empty;
      rec_d   = head_i;
      idx_d   = 2'd0;
    end else if (taken) begin
      idx_d = idx_q + 2'd1;
    end

    out_word_o.item_kind   = is_data ? KIND_DATA : KIND_STATUS;
    out_word_o.status_code = is_data ? ST_OK : rec_q.status;
    out_word_o.byte_count  = is_data ? 24'd0 : rec_q.count;
    out_word_o.run_last    = last;
    case (idx_q)
      2'd0:    out_word_o.data_byte = rec_q.b0;
      2'd1:    out_word_o.data_byte = rec_q.b1;
      default: out_word_o.data_byte = rec_q.b2;
    endcase
    if (!is_data) out_word_o.data_byte = 8'd0;
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign empty = !valid_q;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// top level of the base64 stream decoder: front end, record queue, back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the assertion header
//
// channel   | direction | handshake        | word
// ----------+-----------+------------------+---------------------------------------
// input     | in        | push / full      | char_in, is_final
// result    | out       | pop / empty      | item_kind, data_byte, status_code,
//           |           |                  |   byte_count, run_last
// config    | in        | cfg_we_i         | max_decoded_bytes (24 bit)
//
// one character is taken every cycle while full is low; one result word leaves
// every cycle while pop is high and empty is low, a record unpacking into up to four words
// a result reaches the ports through the queue entry written at the edge that takes its
// character, then the back end record register
// full rises once QueueDepth records wait; only a character that closes a group or
// carries the final flag takes an entry; reset clears payload state, limit 1048576
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64d_pkg::in_word_t  in_word_i,
  input  logic                pop,
  output logic                empty,
  output b64d_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i
);
  import b64d_pkg::*;

  logic [23:0] max_bytes_q;
  logic        accept;
  q_wr_t       q_wr;
  q_stat_t     q_stat;
  rec_t        head;
  logic        q_pop;
  logic        ok_status;
  logic        ok_shape;

  // byte limit register; the user is to write it only between payloads, which the block itself leaves unchecked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RESET;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_wdata_i;
    end
  end

  // a character is taken whenever the queue has room
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .max_bytes_i (max_bytes_q),
    .q_wr_o      (q_wr)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .pop_i  (q_pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  b64d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

  // a waiting ok status word, and what it must look like
  assign ok_status = !empty && out_word_o.item_kind == KIND_STATUS
                     && out_word_o.status_code == ST_OK;
  assign ok_shape  = out_word_o.byte_count != 24'd0 && out_word_o.run_last;

  // the front end never writes into a full queue
  `B64D_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, q_wr.push, !q_stat.full, "push into full queue")

  // while a record waits in the queue, the result register holds a record in the next cycle
  `B64D_ASSERT_NEXT(a_queue_drains, clk_i, rst_ni, !q_stat.empty, !empty, "record not loaded")

  // a good status always reports at least one byte and ends its run
  `B64D_ASSERT_IMPLY(a_ok_has_bytes, clk_i, rst_ni, ok_status, ok_shape, "ok status without bytes")

endmodule
